// File: hw/rtl/dmct_pkg.sv
// Shared types and constants for the direct-mapped write-back cache tag controller.
package dmct_pkg;

   localparam int NUM_LINES   = 128;
   localparam int BLOCK_BYTES = 32;
   localparam int ADDR_BITS   = 32;

   localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
   localparam int INDEX_BITS  = $clog2(NUM_LINES);
   localparam int TAG_BITS    = ADDR_BITS - INDEX_BITS - OFFSET_BITS;
   localparam int COUNT_BITS  = 32;
   localparam int BYTES_BITS  = 6;

   localparam logic [BYTES_BITS-1:0] BLOCK_BYTES_FIELD = BYTES_BITS'(BLOCK_BYTES);
   localparam logic [TAG_BITS-1:0]   NO_EVICT_TAG      = '1;

   // Access kinds.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      logic                 cmd;
   } req_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] byte_offset;
      logic [INDEX_BITS-1:0]  line_index;
      logic [TAG_BITS-1:0]    addr_tag;
      logic                   miss;
      logic                   mem_read;
      logic [BYTES_BITS-1:0]  mem_read_bytes;
      logic                   mem_write;
      logic [BYTES_BITS-1:0]  mem_write_bytes;
      logic                   replacement;
      logic [TAG_BITS-1:0]    evicted_tag;
      logic [COUNT_BITS-1:0]  hit_total;
      logic [COUNT_BITS-1:0]  miss_total;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request and start the tag read
      logic commit;  // resolve the lookup, update state, load the result
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_blocked;  // result register holds a transaction not yet taken
   } dpath_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

endpackage

// File: hw/rtl/direct_mapped_writeback_cache_tags.sv
// Top level of the direct-mapped write-back write-allocate cache tag controller.
//
//   Channel   Direction  Handshake           Payload
//   req_      in         req_valid/req_stall  req_data (address, cmd)
//   rsp_      out        rsp_valid/rsp_stall  rsp_data (one result per transaction)
//
// Each transaction first captures the request and reads the tag memory, whose
// read data is registered, then resolves hit or miss and updates the tag, valid
// and dirty state. No new request is taken while the previous one is in lookup.
// Reset is synchronous and clears the valid and dirty bits, both counters and the
// state machine at once; the tag memory needs no clearing since a tag is only
// compared when its line is valid. A result waits in the output register while
// rsp_stall is high, and the block still captures the next request meanwhile; that
// request then waits in lookup until the output register is free.
module direct_mapped_writeback_cache_tags (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dmct_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dmct_pkg::rsp_type rsp_data
);

   // Commands and status joining the controller and the datapath.
   dmct_pkg::ctrl_cmd_type  cmd;
   dmct_pkg::dpath_sts_type sts;

   // The controller sequences each transaction through capture and lookup.
   dmct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the tag store, line state, counters and the result register.
   dmct_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// File: hw/rtl/dmct_ctrl.sv
// Controller state machine for the cache tag controller.
module dmct_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dmct_pkg::dpath_sts_type sts,
   output dmct_pkg::ctrl_cmd_type  cmd
);

   dmct_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         dmct_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = dmct_pkg::ST_LOOKUP;
            end
         end
         dmct_pkg::ST_LOOKUP: begin
            // The result can only be written once the output register is free.
            if (!sts.rsp_blocked) begin
               cmd.commit = 1'b1;
               state_in   = dmct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/dmct_dpath.sv
// Datapath for the cache tag controller: tag memory, valid and dirty bits, counters, result register.
module dmct_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  dmct_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dmct_pkg::rsp_type       rsp_data,
   input  dmct_pkg::ctrl_cmd_type  cmd,
   output dmct_pkg::dpath_sts_type sts
);

   localparam int OB = dmct_pkg::OFFSET_BITS;
   localparam int IB = dmct_pkg::INDEX_BITS;
   localparam int TB = dmct_pkg::TAG_BITS;
   localparam int AB = dmct_pkg::ADDR_BITS;

   logic [TB-1:0] tag_mem [dmct_pkg::NUM_LINES];
   logic [TB-1:0] tag_rd_ff;

   dmct_pkg::req_type req_ff;
   logic [dmct_pkg::NUM_LINES-1:0] valid_ff, valid_in;
   logic [dmct_pkg::NUM_LINES-1:0] dirty_ff, dirty_in;
   logic [dmct_pkg::COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [dmct_pkg::COUNT_BITS-1:0] miss_cnt_ff, miss_cnt_in;
   dmct_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [IB-1:0] req_index;
   logic [IB-1:0] idx;
   logic [TB-1:0] tag;
   logic          line_valid;
   logic          line_dirty;
   logic          hit;
   logic          is_write;

   assign req_index  = req_data.address[OB +: IB];
   assign idx        = req_ff.address[OB +: IB];
   assign tag        = req_ff.address[AB-1 -: TB];
   assign is_write   = (req_ff.cmd == dmct_pkg::CMD_WRITE);
   assign line_valid = valid_ff[idx];
   assign line_dirty = dirty_ff[idx];
   assign hit        = line_valid && (tag_rd_ff == tag);

   // Tag memory: one read at request capture, one write when a miss allocates.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_rd_ff <= tag_mem[req_index];
      end
      if (cmd.commit && !hit) begin
         tag_mem[idx] <= tag;
      end
   end

   always_comb begin
      valid_in    = valid_ff;
      dirty_in    = dirty_ff;
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      rsp_in      = rsp_ff;
      if (cmd.commit) begin
         if (hit) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
            if (is_write) begin
               dirty_in[idx] = 1'b1;
            end
         end else begin
            miss_cnt_in   = miss_cnt_ff + 1'b1;
            valid_in[idx] = 1'b1;
            dirty_in[idx] = is_write;
         end
         rsp_in.byte_offset     = req_ff.address[OB-1:0];
         rsp_in.line_index      = idx;
         rsp_in.addr_tag        = tag;
         rsp_in.miss            = !hit;
         rsp_in.mem_read        = !hit;
         rsp_in.mem_read_bytes  = hit ? '0 : dmct_pkg::BLOCK_BYTES_FIELD;
         rsp_in.mem_write       = !hit && line_valid && line_dirty;
         rsp_in.mem_write_bytes = (!hit && line_valid && line_dirty) ?
                                  dmct_pkg::BLOCK_BYTES_FIELD : '0;
         rsp_in.replacement     = !hit && line_valid;
         rsp_in.evicted_tag     = (!hit && line_valid) ? tag_rd_ff : dmct_pkg::NO_EVICT_TAG;
         rsp_in.hit_total       = hit_cnt_in;
         rsp_in.miss_total      = miss_cnt_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.rsp_blocked = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule
